@@ src/assert_macros.svh @@
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define PLS_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("pls assertion failed");

// Property that also holds across reset.
`define PLS_ASSERT_RST(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("pls reset assertion failed");

`endif

@@ src/pls_pkg.sv @@
// Shared types and constants of the piecewise linear scaler.
package pls_pkg;

   // Table size and derived widths.
   localparam int MAX_POINTS = 16;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int PCNT_W     = 5;
   localparam int VAL_W      = 16;

   // Command queue between the front and the back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Divider sizes: magnitude of the product and of the denominator.
   localparam int NUM_W  = 32;
   localparam int DEN_W  = 16;
   localparam int STEP_W = $clog2(NUM_W);

   // Request kind codes on the request port.
   localparam logic KIND_WRITE  = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;

   // Control register indexes.
   localparam logic CSR_ENABLE      = 1'b0;
   localparam logic CSR_POINT_COUNT = 1'b1;

   // Saturation limits.
   localparam logic signed [33:0] SAT_MAX = 34'sd32767;
   localparam logic signed [33:0] SAT_MIN = -34'sd32768;

   typedef enum logic {
      CMD_WRITE,
      CMD_SAMPLE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type     kind;
      logic [IDX_W-1:0] index;
      logic [VAL_W-1:0] x;
      logic [VAL_W-1:0] y;
      logic [VAL_W-1:0] sample;
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_X0,
      ST_XN,
      ST_CHK,
      ST_SCAN,
      ST_PA,
      ST_PB,
      ST_CALC,
      ST_MUL,
      ST_PREP,
      ST_DIV,
      ST_FIN,
      ST_DONE
   } state_type;

endpackage

@@ src/pls_front.sv @@
// Front end: accepts requests, classifies them and queues them for the back end.
module pls_front import pls_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   output logic                    req_full,
   input  logic                    req_kind,
   input  logic [3:0]              req_point_index,
   input  logic signed [VAL_W-1:0] req_point_x,
   input  logic signed [VAL_W-1:0] req_point_y,
   input  logic signed [VAL_W-1:0] req_sample,
   output logic                    cmd_valid,
   output cmd_type                 cmd,
   input  logic                    cmd_pop
);

   cmd_type             queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   cmd_type             classified;
   logic                accept;
   logic                keep;
   logic                do_push;
   logic                do_pop;

   // Classify the request; writes beyond the table are dropped here.
   always_comb begin
      classified.kind   = (req_kind == KIND_SAMPLE) ? CMD_SAMPLE : CMD_WRITE;
      classified.index  = req_point_index[IDX_W-1:0];
      classified.x      = req_point_x;
      classified.y      = req_point_y;
      classified.sample = req_sample;
      keep = (req_kind == KIND_SAMPLE) ||
             ({1'b0, req_point_index} < 5'(MAX_POINTS));
   end

   assign req_full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign accept    = req_push && !req_full;
   assign do_push   = accept && keep;
   assign cmd_valid = (count_ff != '0);
   assign do_pop    = cmd_pop && cmd_valid;
   assign cmd       = queue_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         queue_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

@@ src/pls_back.sv @@
// Back end: breakpoint table, serial segment search, iterative divide and result register.
module pls_back import pls_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    cmd_valid,
   input  cmd_type                 cmd,
   output logic                    cmd_pop,
   input  logic                    enable,
   input  logic [PCNT_W-1:0]       point_count,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output logic signed [VAL_W-1:0] rsp_scaled_value,
   output logic                    rsp_range_exceeded,
   output logic                    rsp_config_error
);

   state_type               state_ff, state_in;

   // Breakpoint table and its registered read port.
   logic signed [VAL_W-1:0] mem_x [MAX_POINTS];
   logic signed [VAL_W-1:0] mem_y [MAX_POINTS];
   logic signed [VAL_W-1:0] rd_x_ff;
   logic signed [VAL_W-1:0] rd_y_ff;
   logic [IDX_W-1:0]        rd_addr;
   logic                    mem_we;

   // Working registers of one sample.
   logic signed [VAL_W-1:0] sample_ff;
   logic [IDX_W-1:0]        seg_ff;
   logic                    below_ff;
   logic                    exceed_ff;
   logic                    err_ff;
   logic signed [VAL_W-1:0] xa_ff;
   logic signed [VAL_W-1:0] ya_ff;
   logic signed [VAL_W:0]   dx_ff;
   logic signed [VAL_W:0]   dy_ff;
   logic signed [VAL_W:0]   dn_ff;
   logic signed [33:0]      prod_ff;
   logic                    neg_ff;
   logic [NUM_W-1:0]        num_ff;
   logic [DEN_W-1:0]        den_ff;
   logic [DEN_W:0]          rem_ff;
   logic [STEP_W-1:0]       cnt_ff;
   logic signed [VAL_W-1:0] held_ff;

   // Result register.
   logic                    out_valid_ff;
   logic signed [VAL_W-1:0] out_value_ff;
   logic                    out_exceed_ff;
   logic                    out_err_ff;

   logic [PCNT_W-1:0]       n_eff;
   logic [IDX_W-1:0]        last_idx;
   logic                    few;
   logic                    scan_more;
   logic                    is_write;
   logic                    out_load;
   logic [33:0]             prod_mag;
   logic [DEN_W:0]          dn_mag;
   logic [DEN_W:0]          rem_sh;
   logic                    q_bit;
   logic signed [33:0]      ya_wide;
   logic signed [33:0]      q_wide;
   logic signed [33:0]      res_wide;

   // Point count limited to the table size.
   always_comb begin
      n_eff    = (point_count > PCNT_W'(MAX_POINTS)) ? PCNT_W'(MAX_POINTS) : point_count;
      last_idx = IDX_W'(n_eff - 1'b1);
      few      = (n_eff < PCNT_W'(2));
   end

   assign is_write  = (cmd.kind == CMD_WRITE);
   assign scan_more = (seg_ff < last_idx) && (sample_ff >= rd_x_ff);
   assign out_load  = (state_ff == ST_DONE) && (!out_valid_ff || rsp_pop);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && !is_write) begin
               state_in = (enable && !few) ? ST_X0 : ST_DONE;
            end
         end
         ST_X0:   state_in = ST_XN;
         ST_XN:   state_in = ST_CHK;
         ST_CHK: begin
            state_in = (below_ff || (sample_ff >= rd_x_ff)) ? ST_PA : ST_SCAN;
         end
         ST_SCAN: state_in = scan_more ? ST_SCAN : ST_PA;
         ST_PA:   state_in = ST_PB;
         ST_PB:   state_in = ST_CALC;
         ST_CALC: state_in = (xa_ff == rd_x_ff) ? ST_DONE : ST_MUL;
         ST_MUL:  state_in = ST_PREP;
         ST_PREP: state_in = ST_DIV;
         ST_DIV:  state_in = (cnt_ff == '0) ? ST_FIN : ST_DIV;
         ST_FIN:  state_in = ST_DONE;
         ST_DONE: state_in = out_load ? ST_IDLE : ST_DONE;
         default: state_in = ST_IDLE;
      endcase
   end

   // State outputs: queue pop, table write and table read address.
   always_comb begin
      cmd_pop = 1'b0;
      mem_we  = 1'b0;
      rd_addr = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd_pop = cmd_valid;
            mem_we  = cmd_valid && is_write;
         end
         ST_XN:   rd_addr = last_idx;
         ST_CHK:  rd_addr = IDX_W'(1);
         ST_SCAN: rd_addr = seg_ff + 1'b1;
         ST_PA:   rd_addr = seg_ff - 1'b1;
         ST_PB:   rd_addr = seg_ff;
         default: rd_addr = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Table write port and registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_x[cmd.index] <= $signed(cmd.x);
         mem_y[cmd.index] <= $signed(cmd.y);
      end
      rd_x_ff <= mem_x[rd_addr];
      rd_y_ff <= mem_y[rd_addr];
   end

   // Arithmetic helpers: magnitudes, one divider step and the final sum.
   always_comb begin
      prod_mag = prod_ff[33] ? 34'(-prod_ff) : prod_ff;
      dn_mag   = dn_ff[VAL_W] ? (DEN_W + 1)'(-dn_ff) : dn_ff;
      rem_sh   = {rem_ff[DEN_W-1:0], num_ff[NUM_W-1]};
      q_bit    = (rem_sh >= {1'b0, den_ff});
      ya_wide  = 34'(ya_ff);
      q_wide   = $signed({2'b00, num_ff});
      res_wide = neg_ff ? (ya_wide - q_wide) : (ya_wide + q_wide);
   end

   // Sample datapath.
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (cmd_valid && !is_write) begin
                  sample_ff <= $signed(cmd.sample);
                  exceed_ff <= 1'b0;
                  err_ff    <= 1'b0;
                  if (enable && few) begin
                     err_ff  <= 1'b1;
                     held_ff <= '0;
                  end
               end
            end
            ST_XN: begin
               below_ff <= (sample_ff < rd_x_ff);
            end
            ST_CHK: begin
               if (below_ff) begin
                  seg_ff    <= IDX_W'(1);
                  exceed_ff <= 1'b1;
               end else if (sample_ff >= rd_x_ff) begin
                  seg_ff    <= last_idx;
                  exceed_ff <= (sample_ff > rd_x_ff);
               end else begin
                  seg_ff <= IDX_W'(1);
               end
            end
            ST_SCAN: begin
               if (scan_more) begin
                  seg_ff <= seg_ff + 1'b1;
               end
            end
            ST_PB: begin
               xa_ff <= rd_x_ff;
               ya_ff <= rd_y_ff;
            end
            ST_CALC: begin
               if (xa_ff == rd_x_ff) begin
                  err_ff  <= 1'b1;
                  held_ff <= '0;
               end
               dx_ff <= 17'(sample_ff) - 17'(xa_ff);
               dy_ff <= 17'(rd_y_ff) - 17'(ya_ff);
               dn_ff <= 17'(rd_x_ff) - 17'(xa_ff);
            end
            ST_MUL: begin
               prod_ff <= dx_ff * dy_ff;
            end
            ST_PREP: begin
               num_ff <= prod_mag[NUM_W-1:0];
               den_ff <= dn_mag[DEN_W-1:0];
               neg_ff <= prod_ff[33] ^ dn_ff[VAL_W];
               rem_ff <= '0;
               cnt_ff <= STEP_W'(NUM_W - 1);
            end
            ST_DIV: begin
               // One restoring step: quotient bits shift in from the right.
               rem_ff <= q_bit ? (rem_sh - {1'b0, den_ff}) : rem_sh;
               num_ff <= {num_ff[NUM_W-2:0], q_bit};
               cnt_ff <= cnt_ff - 1'b1;
            end
            ST_FIN: begin
               if (res_wide > SAT_MAX) begin
                  held_ff <= VAL_W'(SAT_MAX);
               end else if (res_wide < SAT_MIN) begin
                  held_ff <= VAL_W'(SAT_MIN);
               end else begin
                  held_ff <= res_wide[VAL_W-1:0];
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Result register towards the response port.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_value_ff  <= held_ff;
         out_exceed_ff <= exceed_ff;
         out_err_ff    <= err_ff;
      end
   end

   assign rsp_empty          = !out_valid_ff;
   assign rsp_scaled_value   = out_value_ff;
   assign rsp_range_exceeded = out_exceed_ff;
   assign rsp_config_error   = out_err_ff;

endmodule

@@ src/piecewise_linear_scaler_unit.sv @@
// Top level of the piecewise linear scaler: control registers, front end and back end.
//
// Requests enter through a queue-style port: an item is taken when req_push is high
// and req_full is low. req_kind selects a breakpoint write (point_index, point_x,
// point_y) or a sample conversion (sample). Writes give no response; each sample
// gives one response on the rsp_ port, read like a queue with rsp_empty and rsp_pop.
// Control registers (enable, point_count) are written through csr_we, csr_index and
// csr_wdata, and should only be changed while the block is idle.
// A four-entry queue between the front end and the back end keeps taking requests
// while a response waits. A breakpoint write is done in the back end's idle state as
// it is popped. A sample goes through the x checks, a serial segment search that
// passes one breakpoint per step (skipped for a sample below the first x or at or
// above the last x), the point reads, the multiply and a restoring divider; samples
// run through the back end one at a time. A disabled block or a short table
// answers without these steps; equal x skips the divide.
// Reset empties the queue and the response register and clears the held value and
// the control registers; the breakpoint table is not cleared. While the receiver
// does not pop, the back end keeps its finished response and waits, and the
// request queue fills up until req_full rises.
module piecewise_linear_scaler_unit import pls_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   output logic                    req_full,
   input  logic                    req_kind,
   input  logic [3:0]              req_point_index,
   input  logic signed [VAL_W-1:0] req_point_x,
   input  logic signed [VAL_W-1:0] req_point_y,
   input  logic signed [VAL_W-1:0] req_sample,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output logic signed [VAL_W-1:0] rsp_scaled_value,
   output logic                    rsp_range_exceeded,
   output logic                    rsp_config_error,
   input  logic                    csr_we,
   input  logic                    csr_index,
   input  logic [PCNT_W-1:0]       csr_wdata
);

   logic              enable_ff;
   logic [PCNT_W-1:0] point_count_ff;
   logic              cmd_valid;
   cmd_type           cmd;
   logic              cmd_pop;

   // Control register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff      <= 1'b0;
         point_count_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ENABLE:      enable_ff      <= csr_wdata[0];
            CSR_POINT_COUNT: point_count_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   pls_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_kind        (req_kind),
      .req_point_index (req_point_index),
      .req_point_x     (req_point_x),
      .req_point_y     (req_point_y),
      .req_sample      (req_sample),
      .cmd_valid       (cmd_valid),
      .cmd             (cmd),
      .cmd_pop         (cmd_pop)
   );

   pls_back u_back (
      .clock              (clock),
      .reset              (reset),
      .cmd_valid          (cmd_valid),
      .cmd                (cmd),
      .cmd_pop            (cmd_pop),
      .enable             (enable_ff),
      .point_count        (point_count_ff),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_scaled_value   (rsp_scaled_value),
      .rsp_range_exceeded (rsp_range_exceeded),
      .rsp_config_error   (rsp_config_error)
   );

endmodule

@@ src/pls_checker.sv @@
// Port-level checker for the piecewise linear scaler and its bind statement.
`include "assert_macros.svh"

module pls_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_push,
   input logic        req_full,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [15:0] rsp_scaled_value,
   input logic        rsp_range_exceeded,
   input logic        rsp_config_error
);

   // All response fields gathered for the hold check.
   logic [17:0] rsp_fields;

   assign rsp_fields = {rsp_scaled_value, rsp_range_exceeded, rsp_config_error};

   // Reset leaves no response pending and room for requests.
   `PLS_ASSERT_RST(a_reset_empty, reset |=> rsp_empty)
   `PLS_ASSERT_RST(a_reset_room, reset |=> !req_full)

   // A response that is not popped stays on the port unchanged.
   `PLS_ASSERT(a_rsp_hold, (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_fields)))

   // A configuration error always reports a zero value.
   `PLS_ASSERT(a_err_zero, (!rsp_empty && rsp_config_error) |-> (rsp_scaled_value == 16'd0))

endmodule

bind piecewise_linear_scaler_unit pls_checker u_pls_checker (
   .clock              (clock),
   .reset              (reset),
   .req_push           (req_push),
   .req_full           (req_full),
   .rsp_empty          (rsp_empty),
   .rsp_pop            (rsp_pop),
   .rsp_scaled_value   (rsp_scaled_value),
   .rsp_range_exceeded (rsp_range_exceeded),
   .rsp_config_error   (rsp_config_error)
);
